>>> sv/tcgm_pkg.sv
package tcgm_pkg;

  // Sample and gain widths.
  localparam int unsigned SampleW = 16;
  localparam int unsigned MagW    = 15;
  localparam int unsigned GainW   = 7;
  localparam int unsigned ProdW   = MagW + GainW;

  // Full-scale gain in percent; writes above it saturate.
  localparam logic [GainW-1:0] GainMax = 7'd100;

  // Division by 100 as a multiply by ceil(2^29 / 100) and a right shift.
  // The result is exact for every product below 2^22.
  localparam int unsigned    RecipShift = 29;
  localparam int unsigned    RecipW     = 23;
  localparam logic [RecipW-1:0] RecipMul = 23'd5368710;
  localparam int unsigned    RecipProdW = ProdW + RecipW;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_OSC_ONE = 2'd0,
    CFG_GAIN_OSC_TWO = 2'd1,
    CFG_GAIN_NOISE   = 2'd2
  } cfg_idx_e;

  // Per-stage load strobes handed from the pipeline control to the lanes.
  typedef struct packed {
    logic load_b;
    logic load_c;
    logic load_d;
    logic load_e;
  } tcgm_adv_t;

endpackage

>>> sv/tcgm_scale.sv
module tcgm_scale (
  input  logic                          clk_i,
  input  tcgm_pkg::tcgm_adv_t           adv_i,
  input  logic [tcgm_pkg::SampleW-1:0]  sample_i,
  input  logic [tcgm_pkg::GainW-1:0]    gain_i,
  output logic [tcgm_pkg::SampleW-1:0]  scaled_o
);
  import tcgm_pkg::*;

  logic [MagW-1:0]       mag;
  logic                  sign_q;
  logic [ProdW-1:0]      prod_d, prod_q;
  logic [RecipProdW-1:0] recip;
  logic [MagW-1:0]       quot;
  logic [SampleW-1:0]    scaled_d, scaled_q;

  // A negative code carries its magnitude as the complement of the low bits.
  assign mag    = sample_i[MagW-1:0] ^ {MagW{sample_i[SampleW-1]}};
  assign prod_d = ProdW'(mag) * ProdW'(gain_i);

  // Divide the product by 100 and restore the sign side.
  assign recip    = RecipProdW'(prod_q) * RecipProdW'(RecipMul);
  assign quot     = recip[RecipShift +: MagW];
  assign scaled_d = sign_q ? {1'b1, ~quot} : {1'b0, quot};

  // Product stage.
  always_ff @(posedge clk_i) begin
    if (adv_i.load_b) begin
      sign_q <= sample_i[SampleW-1];
      prod_q <= prod_d;
    end
  end

  // Scaled sample stage.
  always_ff @(posedge clk_i) begin
    if (adv_i.load_c) begin
      scaled_q <= scaled_d;
    end
  end

  assign scaled_o = scaled_q;

endmodule

>>> sv/tcgm_mix.sv
module tcgm_mix (
  input  logic                          clk_i,
  input  tcgm_pkg::tcgm_adv_t           adv_i,
  input  logic [tcgm_pkg::SampleW-1:0]  osc_one_i,
  input  logic [tcgm_pkg::SampleW-1:0]  osc_two_i,
  input  logic [tcgm_pkg::SampleW-1:0]  noise_i,
  output logic [tcgm_pkg::SampleW-1:0]  mix_o
);
  import tcgm_pkg::*;

  logic [SampleW-1:0] osc_avg_d, osc_avg_q;
  logic [SampleW-1:0] noise_q;
  logic [SampleW-1:0] mix_avg;
  logic [SampleW-1:0] mix_d, mix_q;

  // Four-case average of two complement-coded samples.
  function automatic logic [SampleW-1:0] avg_pair(logic [SampleW-1:0] a,
                                                  logic [SampleW-1:0] b);
    logic [SampleW:0]   sum;
    logic [SampleW-1:0] p;
    logic [SampleW-1:0] n;
    logic [SampleW-1:0] r;
    sum = '0;
    p   = a[SampleW-1] ? b : a;
    n   = a[SampleW-1] ? a : b;
    if (a[SampleW-1] && b[SampleW-1]) begin
      sum = {1'b0, ~a} + {1'b0, ~b};
      r   = ~sum[SampleW:1];
    end else if (!a[SampleW-1] && !b[SampleW-1]) begin
      sum = {1'b0, a} + {1'b0, b};
      r   = sum[SampleW:1];
    end else if (n < ~p) begin
      r = {1'b0, n[SampleW-1:1]} - {1'b0, ~p[SampleW-1:1]};
    end else begin
      r = ~({1'b0, ~n[SampleW-1:1]} - {1'b0, p[SampleW-1:1]});
    end
    return r;
  endfunction

  assign osc_avg_d = avg_pair(osc_one_i, osc_two_i);
  assign mix_avg   = avg_pair(osc_avg_q, noise_q);
  // A silent result is sent as one so the DAC never sees a zero code.
  assign mix_d     = (mix_avg == '0) ? SampleW'(1) : mix_avg;

  // Oscillator average stage.
  always_ff @(posedge clk_i) begin
    if (adv_i.load_d) begin
      osc_avg_q <= osc_avg_d;
      noise_q   <= noise_i;
    end
  end

  // Output stage.
  always_ff @(posedge clk_i) begin
    if (adv_i.load_e) begin
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

endmodule

>>> sv/three_channel_gain_mixer_top.sv
// Three-channel gain mixer.
// The slave stream carries one beat per audio sample: the first oscillator,
// the second oscillator and the noise sample, each a 16-bit complement code.
// Each sample is scaled by its own percent gain, the two oscillators are
// averaged, and that average is averaged with the noise sample. The master
// stream returns one 16-bit mixed code per input beat, never zero.
// Gains are written through cfg_we_i / cfg_idx_i / cfg_data_i while the
// stream is idle; a value above 100 is stored as 100, index 3 is ignored.
// A beat passes five registers: input register, gain product, divide by 100,
// oscillator average, final average. One beat is accepted per cycle while
// s_axis_tready is high; each stage holds at most one beat and moves on
// whenever the stage after it is empty or moving.
// When the receiver stalls, the output beat holds and the stages behind it
// keep filling until all five are occupied, then s_axis_tready drops.
// Reset clears every stage's valid bit and sets all three gains to 100.
module three_channel_gain_mixer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Slave stream; tdata: osc_one_in, osc_two_in, noise_in (from bit 0 up).
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [3*tcgm_pkg::SampleW-1:0] s_axis_tdata,
  // Master stream; tdata: mix_out.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tcgm_pkg::SampleW-1:0]  m_axis_tdata,
  // Gain register write port.
  input  logic                          cfg_we_i,
  input  logic [tcgm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tcgm_pkg::GainW-1:0]    cfg_data_i
);
  import tcgm_pkg::*;

  logic [GainW-1:0]   gain_one_q, gain_two_q, gain_noise_q;
  logic [GainW-1:0]   gain_wr;
  logic [3*SampleW-1:0] in_q;
  logic               v_a_q, v_b_q, v_c_q, v_d_q, v_e_q;
  logic               rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;
  tcgm_adv_t          adv;
  logic [SampleW-1:0] sc_one, sc_two, sc_noise;

  // Each stage takes a new beat when it is empty or its content moves on.
  assign rdy_e = !v_e_q || m_axis_tready;
  assign rdy_d = !v_d_q || rdy_e;
  assign rdy_c = !v_c_q || rdy_d;
  assign rdy_b = !v_b_q || rdy_c;
  assign rdy_a = !v_a_q || rdy_b;

  assign adv.load_b = rdy_b;
  assign adv.load_c = rdy_c;
  assign adv.load_d = rdy_d;
  assign adv.load_e = rdy_e;

  assign s_axis_tready = rdy_a;
  assign m_axis_tvalid = v_e_q;

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
      v_e_q <= 1'b0;
    end else begin
      if (rdy_a) v_a_q <= s_axis_tvalid;
      if (rdy_b) v_b_q <= v_a_q;
      if (rdy_c) v_c_q <= v_b_q;
      if (rdy_d) v_d_q <= v_c_q;
      if (rdy_e) v_e_q <= v_d_q;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      in_q <= s_axis_tdata;
    end
  end

  // Gain registers, saturated at full scale.
  assign gain_wr = (cfg_data_i > GainMax) ? GainMax : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_one_q   <= GainMax;
      gain_two_q   <= GainMax;
      gain_noise_q <= GainMax;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN_OSC_ONE: gain_one_q   <= gain_wr;
        CFG_GAIN_OSC_TWO: gain_two_q   <= gain_wr;
        CFG_GAIN_NOISE:   gain_noise_q <= gain_wr;
        default: ;
      endcase
    end
  end

  // One scaling lane per channel.
  tcgm_scale u_scale_one (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .sample_i (in_q[0 +: SampleW]),
    .gain_i   (gain_one_q),
    .scaled_o (sc_one)
  );

  tcgm_scale u_scale_two (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .sample_i (in_q[SampleW +: SampleW]),
    .gain_i   (gain_two_q),
    .scaled_o (sc_two)
  );

  tcgm_scale u_scale_noise (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .sample_i (in_q[2*SampleW +: SampleW]),
    .gain_i   (gain_noise_q),
    .scaled_o (sc_noise)
  );

  tcgm_mix u_mix (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .osc_one_i (sc_one),
    .osc_two_i (sc_two),
    .noise_i   (sc_noise),
    .mix_o     (m_axis_tdata)
  );

  // A valid result never carries a zero code.
  a_no_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata != '0)
    else $error("zero mix code on output");

  // Gains stay within full scale.
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_one_q <= GainMax && gain_two_q <= GainMax && gain_noise_q <= GainMax)
    else $error("gain register above full scale");

  // An accepted beat lands in the input register.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v_a_q)
    else $error("accepted beat lost at input register");

  // A beat waiting behind a blocked output stage is kept.
  a_hold_d: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_d_q && !rdy_e |=> v_d_q && v_e_q)
    else $error("beat dropped while output stalled");

endmodule
